// ----- rtl/ils_pkg.sv -----
// shared types and defaults for the indexed list store
package ils_pkg;

  localparam int unsigned ILS_CAPACITY   = 64;
  localparam int unsigned ILS_VALUE_BITS = 32;

  typedef enum logic [2:0] {
    KIND_APPEND  = 3'd0,
    KIND_INSERT  = 3'd1,
    KIND_READ    = 3'd2,
    KIND_DELETE  = 3'd3,
    KIND_REPLACE = 3'd4,
    KIND_FIND    = 3'd5,
    KIND_CLEAR   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SET,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     find;
  } cell_ctrl_t;

endpackage

// ----- rtl/ils_cell.sv -----
// one list entry with its neighbor links and a lane of the scan chain
module ils_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned CAPACITY   = ils_pkg::ILS_CAPACITY,
  parameter int unsigned VALUE_BITS = ils_pkg::ILS_VALUE_BITS,
  localparam int unsigned PosW      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  ils_pkg::cell_ctrl_t   ctrl_i,
  input  logic [PosW-1:0]       pos_i,
  input  logic [PosW-1:0]       count_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] left_entry_i,
  input  logic [VALUE_BITS-1:0] right_entry_i,
  input  logic                  lane_flag_i,
  input  logic [VALUE_BITS-1:0] lane_data_i,
  output logic [VALUE_BITS-1:0] entry_o,
  output logic                  lane_flag_o,
  output logic [VALUE_BITS-1:0] lane_data_o
);

  localparam logic [PosW-1:0] IdxV = PosW'(IDX);

  logic [VALUE_BITS-1:0] entry_q, entry_d;
  logic                  lane_flag_q, lane_flag_d;
  logic [VALUE_BITS-1:0] lane_data_q, lane_data_d;

  always_comb begin
    entry_d     = entry_q;
    lane_flag_d = lane_flag_q;
    lane_data_d = lane_data_q;
    unique case (ctrl_i.op)
      ils_pkg::CELL_INSERT: begin
        if (IdxV == pos_i) begin
          entry_d = value_i;
        end else if (IdxV > pos_i) begin
          entry_d = left_entry_i;
        end
      end
      ils_pkg::CELL_DELETE: begin
        if (IdxV >= pos_i) begin
          entry_d = right_entry_i;
        end
      end
      ils_pkg::CELL_SET: begin
        if (IdxV == pos_i) begin
          entry_d = value_i;
        end
      end
      ils_pkg::CELL_LOAD: begin
        // find flags live matches, read flags the addressed entry
        lane_flag_d = ctrl_i.find ? ((entry_q == value_i) && (IdxV < count_i))
                                  : (IdxV == pos_i);
        lane_data_d = entry_q;
      end
      ils_pkg::CELL_SHIFT: begin
        lane_flag_d = lane_flag_i;
        lane_data_d = lane_data_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q     <= entry_d;
    lane_flag_q <= lane_flag_d;
    lane_data_q <= lane_data_d;
  end

  assign entry_o     = entry_q;
  assign lane_flag_o = lane_flag_q;
  assign lane_data_o = lane_data_q;

endmodule

// ----- rtl/indexed_list_store_core.sv -----
// indexed list store: control, result register and the row of entry cells
// append, insert, delete, replace and clear act when accepted; result is registered next cycle
// read and find load a scan lane in every cell, then shift it toward cell 0 one entry a
// cycle until the flagged entry or the last live entry reaches cell 0
// one transaction at a time; a new request is taken only when idle and the result register is free
// reset clears the entry count and handshake state; entry bits stay undefined until written
module indexed_list_store_core #(
  parameter int unsigned CAPACITY   = ils_pkg::ILS_CAPACITY,
  parameter int unsigned VALUE_BITS = ils_pkg::ILS_VALUE_BITS,
  localparam int unsigned PosW      = $clog2(CAPACITY + 1),
  localparam int unsigned IdxW      = $clog2(CAPACITY)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            kind_i,
  input  logic [PosW-1:0]       position_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic [IdxW-1:0]       found_position_o,
  output logic [PosW-1:0]       count_o
);

  localparam logic [PosW-1:0] CapV = PosW'(CAPACITY);

  ils_pkg::state_e     state_q, state_d;
  logic [PosW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     k_q, k_d;
  logic [IdxW-1:0]     k_last_q, k_last_d;
  logic                find_q, find_d;
  logic                out_valid_q;
  ils_pkg::status_e    status_q;
  logic [VALUE_BITS-1:0] rd_q;
  logic [IdxW-1:0]     fpos_q;

  ils_pkg::cell_ctrl_t ctrl;
  logic [PosW-1:0]     cell_pos;
  logic                in_fire, out_free, scan_start, scan_done;
  logic                res_load;
  ils_pkg::status_e    res_status;
  logic [VALUE_BITS-1:0] res_rd;
  logic [IdxW-1:0]     res_fpos;

  logic [VALUE_BITS-1:0] entry_w     [CAPACITY];
  logic                  lane_flag_w [CAPACITY];
  logic [VALUE_BITS-1:0] lane_data_w [CAPACITY];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ils_pkg::ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_done  = lane_flag_w[0] || (k_q == k_last_q);

  // datapath control and result selection
  always_comb begin
    ctrl.op    = ils_pkg::CELL_HOLD;
    ctrl.find  = 1'b0;
    cell_pos   = position_i;
    cnt_d      = cnt_q;
    k_d        = k_q;
    k_last_d   = k_last_q;
    find_d     = find_q;
    scan_start = 1'b0;
    res_load   = 1'b0;
    res_status = ils_pkg::STATUS_OK;
    res_rd     = '0;
    res_fpos   = '0;
    unique case (state_q)
      ils_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          k_d      = '0;
          k_last_d = IdxW'(cnt_q - 1'b1);
          unique case (kind_i)
            ils_pkg::KIND_APPEND: begin
              if (cnt_q == CapV) begin
                res_status = ils_pkg::STATUS_FULL;
              end else begin
                ctrl.op  = ils_pkg::CELL_INSERT;
                cell_pos = cnt_q;
                cnt_d    = cnt_q + 1'b1;
              end
            end
            ils_pkg::KIND_INSERT: begin
              if (position_i > cnt_q) begin
                res_status = ils_pkg::STATUS_RANGE;
              end else if (cnt_q == CapV) begin
                res_status = ils_pkg::STATUS_FULL;
              end else begin
                ctrl.op = ils_pkg::CELL_INSERT;
                cnt_d   = cnt_q + 1'b1;
              end
            end
            ils_pkg::KIND_READ: begin
              if (position_i >= cnt_q) begin
                res_status = ils_pkg::STATUS_RANGE;
              end else begin
                ctrl.op    = ils_pkg::CELL_LOAD;
                find_d     = 1'b0;
                scan_start = 1'b1;
                res_load   = 1'b0;
              end
            end
            ils_pkg::KIND_DELETE: begin
              if (position_i >= cnt_q) begin
                res_status = ils_pkg::STATUS_RANGE;
              end else begin
                ctrl.op = ils_pkg::CELL_DELETE;
                cnt_d   = cnt_q - 1'b1;
              end
            end
            ils_pkg::KIND_REPLACE: begin
              if (position_i >= cnt_q) begin
                res_status = ils_pkg::STATUS_RANGE;
              end else begin
                ctrl.op = ils_pkg::CELL_SET;
              end
            end
            ils_pkg::KIND_FIND: begin
              if (cnt_q == '0) begin
                res_status = ils_pkg::STATUS_MISSING;
              end else begin
                ctrl.op    = ils_pkg::CELL_LOAD;
                ctrl.find  = 1'b1;
                find_d     = 1'b1;
                scan_start = 1'b1;
                res_load   = 1'b0;
              end
            end
            ils_pkg::KIND_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ils_pkg::ST_SCAN: begin
        if (scan_done) begin
          // hold the lane until the result register is free
          if (out_free) begin
            res_load = 1'b1;
            if (find_q) begin
              if (lane_flag_w[0]) begin
                res_fpos = k_q;
              end else begin
                res_status = ils_pkg::STATUS_MISSING;
              end
            end else begin
              res_rd = lane_data_w[0];
            end
          end
        end else begin
          ctrl.op = ils_pkg::CELL_SHIFT;
          k_d     = k_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ils_pkg::ST_IDLE: begin
        if (in_fire && scan_start) begin
          state_d = ils_pkg::ST_SCAN;
        end
      end
      ils_pkg::ST_SCAN: begin
        if (scan_done && out_free) begin
          state_d = ils_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ils_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ils_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    k_last_q <= k_last_d;
    find_q   <= find_d;
    if (res_load) begin
      status_q <= res_status;
      rd_q     <= res_rd;
      fpos_q   <= res_fpos;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_w, right_w, next_data_w;
    logic                  next_flag_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_lo
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w     = '0;
      assign next_flag_w = 1'b0;
      assign next_data_w = '0;
    end else begin : g_mid_hi
      assign right_w     = entry_w[i+1];
      assign next_flag_w = lane_flag_w[i+1];
      assign next_data_w = lane_data_w[i+1];
    end
    ils_cell #(
      .IDX        (i),
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .pos_i         (cell_pos),
      .count_i       (cnt_q),
      .value_i       (value_i),
      .left_entry_i  (left_w),
      .right_entry_i (right_w),
      .lane_flag_i   (next_flag_w),
      .lane_data_i   (next_data_w),
      .entry_o       (entry_w[i]),
      .lane_flag_o   (lane_flag_w[i]),
      .lane_data_o   (lane_data_w[i])
    );
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign read_value_o     = rd_q;
  assign found_position_o = fpos_q;
  assign count_o          = cnt_q;

endmodule
